FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define DTOK_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define DTOK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/dtok_pkg.sv
`default_nettype none

package dtok_pkg;

  localparam logic [15:0] MAX_STRING_LEN = 16'hFFFF;
  localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
  localparam logic [7:0]  QUOTE_DOUBLE   = 8'h22;
  localparam logic [7:0]  QUOTE_SINGLE   = 8'h27;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 64;

  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned OUTQ_PTR_W = 2;
  localparam int unsigned OUTQ_CNT_W = 3;

  typedef enum logic [1:0] {
    TAIL_NORMAL     = 2'd0,
    TAIL_EMPTY_SEEK = 2'd1,
    TAIL_DONE       = 2'd2,
    TAIL_TRIM       = 2'd3
  } tail_phase_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DELIM_MAP_0 = 3'd0,
    CFG_DELIM_MAP_1 = 3'd1,
    CFG_DELIM_MAP_2 = 3'd2,
    CFG_DELIM_MAP_3 = 3'd3,
    CFG_ALLOW_EMPTY = 3'd4,
    CFG_QUOTE_AWARE = 3'd5,
    CFG_MAX_TOKENS  = 3'd6
  } cfg_index_t;

  typedef enum logic {
    KIND_TOKEN = 1'b0,
    KIND_COUNT = 1'b1
  } record_kind_t;

  typedef struct packed {
    logic [255:0] delim_map;
    logic         allow_empty;
    logic         quote_aware;
    logic [15:0]  max_tokens;
  } dtok_cfg_t;

  typedef struct packed {
    logic        in_quote;
    logic        prior_was_delimiter;
    logic [15:0] current_token_start;
    logic [15:0] byte_position;
    logic [15:0] tokens_so_far;
    tail_phase_t tail_phase;
    logic [15:0] last_content_end;
  } dtok_state_t;

  localparam dtok_state_t STATE_RESET = '{
    in_quote:            1'b0,
    prior_was_delimiter: 1'b1,
    current_token_start: 16'd0,
    byte_position:       16'd0,
    tokens_so_far:       16'd0,
    tail_phase:          TAIL_NORMAL,
    last_content_end:    16'd0
  };

  // what one request produces: an optional token record, an optional count record
  typedef struct packed {
    logic        tok_valid;
    logic [15:0] tok_start;
    logic [15:0] tok_length;
    logic        cnt_valid;
    logic [15:0] count;
  } dtok_scan_t;

  typedef struct packed {
    logic        record_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [15:0] token_count;
    logic        last_of_run;
  } dtok_rec_t;

endpackage

`default_nettype wire

FILE: rtl/core/dtok_byte_if.sv
`default_nettype none

interface dtok_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_string;

  modport source (output valid, output byte_in, output end_of_string, input ready);
  modport sink (input valid, input byte_in, input end_of_string, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/dtok_rec_if.sv
`default_nettype none

interface dtok_rec_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [15:0] token_count;
  logic        last_of_run;

  modport source (output valid, output record_kind, output token_start,
                  output token_length, output token_count, output last_of_run,
                  input ready);
  modport sink (input valid, input record_kind, input token_start,
                input token_length, input token_count, input last_of_run,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/core/dtok_cfg_if.sv
`default_nettype none

interface dtok_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/dtok_scan.sv
`default_nettype none

module dtok_scan (
  input  dtok_pkg::dtok_state_t st,
  input  dtok_pkg::dtok_cfg_t   cfg,
  input  logic [7:0]            byte_in,
  input  logic                  end_of_string,
  output dtok_pkg::dtok_state_t st_next,
  output dtok_pkg::dtok_scan_t  res
);
  import dtok_pkg::*;

  dtok_state_t s;
  logic [15:0] pos;
  logic [15:0] pos_inc;
  logic        active;
  logic        quote_hit;
  logic        q_next;
  logic        is_delim;
  logic        emit;
  logic [15:0] tok_start;
  logic [15:0] tok_end;
  logic [15:0] tokens_next;

  always_comb begin
    s         = st;
    pos       = st.byte_position;
    pos_inc   = st.byte_position + 16'd1;
    active    = (st.byte_position != MAX_STRING_LEN);
    quote_hit = cfg.quote_aware && (byte_in == QUOTE_DOUBLE || byte_in == QUOTE_SINGLE);
    q_next    = 1'b0;
    is_delim  = 1'b0;
    emit      = 1'b0;
    tok_start = 16'd0;
    tok_end   = 16'd0;

    if (active) begin
      // token limit: last token ends at a delimiter if allow_empty, else at end
      if (s.tail_phase == TAIL_NORMAL && cfg.max_tokens != 16'd0 &&
          ({1'b0, st.tokens_so_far} + 17'd1) == {1'b0, cfg.max_tokens}) begin
        s.in_quote = 1'b0;
        if (cfg.allow_empty) begin
          s.tail_phase = TAIL_EMPTY_SEEK;
        end else begin
          s.tail_phase = TAIL_TRIM;
          s.prior_was_delimiter = 1'b1;
        end
      end

      q_next   = s.in_quote ^ quote_hit;
      is_delim = !q_next && cfg.delim_map[byte_in];
      if (s.tail_phase != TAIL_DONE) begin
        s.in_quote = q_next;
      end

      unique case (s.tail_phase)
        TAIL_NORMAL: begin
          if (cfg.allow_empty) begin
            if (is_delim) begin
              emit = 1'b1;
              tok_start = s.current_token_start;
              tok_end = pos;
              s.current_token_start = pos_inc;
              s.prior_was_delimiter = 1'b1;
            end else begin
              s.prior_was_delimiter = 1'b0;
            end
          end else begin
            if (is_delim) begin
              if (!s.prior_was_delimiter) begin
                emit = 1'b1;
                tok_start = s.current_token_start;
                tok_end = pos;
              end
              s.prior_was_delimiter = 1'b1;
            end else begin
              if (s.prior_was_delimiter) begin
                s.current_token_start = pos;
              end
              s.prior_was_delimiter = 1'b0;
            end
          end
        end
        TAIL_EMPTY_SEEK: begin
          if (is_delim) begin
            emit = 1'b1;
            tok_start = s.current_token_start;
            tok_end = pos;
            s.tail_phase = TAIL_DONE;
          end
        end
        TAIL_TRIM: begin
          if (!is_delim) begin
            if (s.prior_was_delimiter) begin
              s.current_token_start = pos;
              s.prior_was_delimiter = 1'b0;
            end
            s.last_content_end = pos_inc;
          end
        end
        TAIL_DONE: begin
        end
      endcase
      s.byte_position = pos_inc;
    end

    // flush the pending token; never coincides with a token from the scan above
    if (end_of_string) begin
      unique case (s.tail_phase)
        TAIL_NORMAL: begin
          if (!s.prior_was_delimiter) begin
            emit = 1'b1;
            tok_start = s.current_token_start;
            tok_end = s.byte_position;
          end
        end
        TAIL_EMPTY_SEEK: begin
          emit = 1'b1;
          tok_start = s.current_token_start;
          tok_end = s.byte_position;
        end
        TAIL_TRIM: begin
          if (!s.prior_was_delimiter) begin
            emit = 1'b1;
            tok_start = s.current_token_start;
            tok_end = s.last_content_end;
          end
        end
        TAIL_DONE: begin
        end
      endcase
    end

    tokens_next = (emit && s.tokens_so_far != COUNT_MAX) ? s.tokens_so_far + 16'd1
                                                          : s.tokens_so_far;
    s.tokens_so_far = tokens_next;

    res.tok_valid  = emit;
    res.tok_start  = tok_start;
    res.tok_length = (tok_end >= tok_start) ? tok_end - tok_start : 16'd0;
    res.cnt_valid  = end_of_string;
    res.count      = tokens_next;

    st_next = end_of_string ? STATE_RESET : s;
  end

endmodule

`default_nettype wire

FILE: rtl/core/dtok_outq.sv
`default_nettype none
`include "assert_macros.svh"

module dtok_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  dtok_pkg::dtok_scan_t res,
  output logic                 room,
  output logic                 head_valid,
  input  logic                 head_ready,
  output dtok_pkg::dtok_rec_t  head
);
  import dtok_pkg::*;

  dtok_rec_t               q [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0]   wr_ptr;
  logic [OUTQ_PTR_W-1:0]   rd_ptr;
  logic [OUTQ_CNT_W-1:0]   fill;
  logic [1:0]              push_n;
  logic                    pop;
  dtok_rec_t               tok_rec;
  dtok_rec_t               cnt_rec;
  dtok_rec_t               e0;
  dtok_rec_t               e1;

  always_comb begin
    tok_rec.record_kind  = KIND_TOKEN;
    tok_rec.token_start  = res.tok_start;
    tok_rec.token_length = res.tok_length;
    tok_rec.token_count  = 16'd0;
    tok_rec.last_of_run  = !res.cnt_valid;

    cnt_rec.record_kind  = KIND_COUNT;
    cnt_rec.token_start  = 16'd0;
    cnt_rec.token_length = 16'd0;
    cnt_rec.token_count  = res.count;
    cnt_rec.last_of_run  = 1'b1;

    e0 = res.tok_valid ? tok_rec : cnt_rec;
    e1 = cnt_rec;
    push_n = push ? ({1'b0, res.tok_valid} + {1'b0, res.cnt_valid}) : 2'd0;
  end

  assign pop        = head_valid && head_ready;
  assign head_valid = (fill != '0);
  assign head       = q[rd_ptr];
  // two free slots, so a request with both records always fits
  assign room       = (fill <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + OUTQ_PTR_W'(push_n);
      rd_ptr <= rd_ptr + OUTQ_PTR_W'(pop);
      fill   <= fill + OUTQ_CNT_W'(push_n) - OUTQ_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q[wr_ptr] <= e0;
    end
    if (push_n == 2'd2) begin
      q[wr_ptr + OUTQ_PTR_W'(1)] <= e1;
    end
  end

  `DTOK_ASSERT(a_fill_bound, fill <= OUTQ_CNT_W'(OUTQ_DEPTH), "result queue overfilled")
  `DTOK_ASSERT(a_push_room, (push_n == 2'd0) || room, "push without two free slots")
  `DTOK_ASSERT_NEXT(a_drain_last, (fill == OUTQ_CNT_W'(1)) && pop && (push_n == 2'd0), fill == '0, "queue did not drain")

endmodule

`default_nettype wire

FILE: rtl/core/delimiter_tokenizer_core.sv
// channel  | dir | handshake     | payload
// bytes    | in  | valid / ready | byte_in, end_of_string
// records  | out | valid / ready | record_kind, token_start, token_length,
//          |     |               | token_count, last_of_run
// cfg      | in  | valid / ready | index, data (always ready)
//
// one byte is taken per cycle while the queue has room; its records sit in
// a 4-entry result queue, the token record ahead of the count record
// bytes stall while fewer than two queue slots are free
// records are registered in the queue before they appear on the output
// rst is synchronous: clears config registers, string state and the queue
`default_nettype none
`include "assert_macros.svh"

module delimiter_tokenizer_core (
  input  logic       clk,
  input  logic       rst,
  dtok_byte_if.sink  bytes,
  dtok_rec_if.source records,
  dtok_cfg_if.sink   cfg
);
  import dtok_pkg::*;

  dtok_cfg_t   cfg_q;
  dtok_state_t st;
  dtok_state_t st_next;
  dtok_scan_t  res;
  dtok_rec_t   head;
  logic        room;
  logic        accept;

  assign cfg.ready   = 1'b1;
  assign bytes.ready = room;
  assign accept      = bytes.valid && bytes.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_DELIM_MAP_0: cfg_q.delim_map[63:0]    <= cfg.data;
        CFG_DELIM_MAP_1: cfg_q.delim_map[127:64]  <= cfg.data;
        CFG_DELIM_MAP_2: cfg_q.delim_map[191:128] <= cfg.data;
        CFG_DELIM_MAP_3: cfg_q.delim_map[255:192] <= cfg.data;
        CFG_ALLOW_EMPTY: cfg_q.allow_empty        <= cfg.data[0];
        CFG_QUOTE_AWARE: cfg_q.quote_aware        <= cfg.data[0];
        CFG_MAX_TOKENS:  cfg_q.max_tokens         <= cfg.data[15:0];
        default: begin
        end
      endcase
    end
  end

  dtok_scan u_scan (
    .st            (st),
    .cfg           (cfg_q),
    .byte_in       (bytes.byte_in),
    .end_of_string (bytes.end_of_string),
    .st_next       (st_next),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

  dtok_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .res        (res),
    .room       (room),
    .head_valid (records.valid),
    .head_ready (records.ready),
    .head       (head)
  );

  assign records.record_kind  = head.record_kind;
  assign records.token_start  = head.token_start;
  assign records.token_length = head.token_length;
  assign records.token_count  = head.token_count;
  assign records.last_of_run  = head.last_of_run;

  `DTOK_ASSERT_NEXT(a_eos_clears, accept && bytes.end_of_string, (st.byte_position == 16'd0) && (st.tokens_so_far == 16'd0) && (st.tail_phase == TAIL_NORMAL), "string state not cleared")
  `DTOK_ASSERT(a_count_is_last, !(records.valid && records.record_kind == KIND_COUNT) || records.last_of_run, "count record not last of run")

endmodule

`default_nettype wire
